// File: rtl/core/ypr_pkg.sv
// Shared constants, types and helper functions for the YPR telemetry line parser.
// No dependencies; compiled first.
`default_nettype none

package ypr_pkg;

	localparam int MAX_LINE    = 64;
	localparam int FRAC_DIGITS = 3;

	localparam int ANGLE_W    = 32;
	localparam int LINE_CNT_W = $clog2(MAX_LINE + 1);
	localparam int FRAC_W     = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
	localparam int POW_W      = $clog2((10 ** FRAC_DIGITS) + 1);
	localparam int TOK_W      = 3;
	localparam int HDR_W      = 3;

	localparam logic [ANGLE_W-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	localparam logic [7:0] HDR_TEXT [4] = '{8'h23, 8'h59, 8'h50, 8'h52};
	localparam logic [HDR_W-1:0] HDR_LEN = 3'd4;

	// Number scanner phases
	localparam logic [1:0] PH_SIGN = 2'd0;
	localparam logic [1:0] PH_INT  = 2'd1;
	localparam logic [1:0] PH_FRAC = 2'd2;
	localparam logic [1:0] PH_STOP = 2'd3;

	typedef struct packed {
		logic [ANGLE_W-1:0] accum;
		logic [FRAC_W-1:0]  frac;
		logic               neg;
	} number_t;

	// Power of ten selected by a small exponent; the running product folds to constants.
	function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
		logic [POW_W-1:0] r;
		logic [POW_W-1:0] p;
		r = '0;
		p = POW_W'(1);
		for (int i = 0; i <= FRAC_DIGITS; i++) begin
			if (k == FRAC_W'(i))
				r = p;
			p = POW_W'(p * 10);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ypr_byte_if.sv
// Byte channel interface: valid/ready handshake carrying one received character.
// Depends on nothing.
`default_nettype none

interface ypr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ypr_result_if.sv
// Result channel interface: valid/ready handshake carrying the parsed angles of one line.
// Depends on ypr_pkg.
`default_nettype none

interface ypr_result_if;
	import ypr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] yaw_milli;
	logic signed [ANGLE_W-1:0] pitch_milli;
	logic signed [ANGLE_W-1:0] roll_milli;
	logic                      header_matched;
	logic [2:0]                updated_mask;

	modport source (output valid, output yaw_milli, output pitch_milli, output roll_milli,
		output header_matched, output updated_mask, input ready);
	modport sink   (input valid, input yaw_milli, input pitch_milli, input roll_milli,
		input header_matched, input updated_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ypr_value_scale.sv
// Turns a scanned decimal (magnitude, fraction digit count, sign) into saturated
// fixed point with FRAC_DIGITS fraction digits. Depends on ypr_pkg.
`default_nettype none

module ypr_value_scale (
	input  ypr_pkg::number_t                  num,
	output logic signed [ypr_pkg::ANGLE_W-1:0] value
);
	import ypr_pkg::*;

	localparam int PROD_W = ANGLE_W + POW_W;

	logic [FRAC_W-1:0]  shift_k;
	logic [PROD_W-1:0]  prod;
	logic [ANGLE_W-1:0] mag;

	// Missing fraction digits scale the magnitude up; saturation is monotone,
	// so one multiply and one clamp match repeated multiply-and-clamp.
	assign shift_k = FRAC_W'(FRAC_DIGITS) - num.frac;
	assign prod    = PROD_W'(num.accum) * PROD_W'(pow10(shift_k));
	assign mag     = (prod > PROD_W'(MAG_CAP)) ? MAG_CAP : prod[ANGLE_W-1:0];

	always_comb begin
		if (num.neg)
			value = signed'(ANGLE_W'(0) - mag);
		else if (mag > POS_MAX)
			value = signed'(POS_MAX);
		else
			value = signed'(mag);
	end

endmodule

`default_nettype wire

// File: rtl/core/ypr_telemetry_line_parser.sv
// Top level of the YPR telemetry line parser: byte input register, per-byte parse
// update and one-deep result register. Depends on ypr_pkg, ypr_byte_if,
// ypr_result_if and ypr_value_scale.
//
//   channel  | dir | beat contents                                   | per beat
//   ---------+-----+-------------------------------------------------+-----------------
//   rx       | in  | rx_byte                                         | one character
//   angles   | out | yaw/pitch/roll_milli, header_matched, upd. mask | one non-empty line
//
// Throughput is one byte per clock. A byte waits in the input register, where the
// whole parse update is applied; a newline that ends a non-empty line loads the
// result register as it leaves the input register. rx stalls only when a newline
// ending a non-empty line waits in the input register while the result register
// still holds an untaken beat. Reset clears all parse state and the held angles to
// zero; no clearing pass is needed.
`default_nettype none

module ypr_telemetry_line_parser (
	input  wire            clk,
	input  wire            arst_n,
	ypr_byte_if.sink       rx,
	ypr_result_if.source   angles
);
	import ypr_pkg::*;

	// ---------------------------------------------------------------- input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// ---------------------------------------------------------------- parse state
	logic [LINE_CNT_W-1:0] line_cnt_q;
	logic [TOK_W-1:0]      tok_q;
	logic                  inside_q;
	logic [HDR_W-1:0]      hdr_prog_q;
	logic                  hdr_fail_q;
	logic                  dead_q;
	logic [ANGLE_W-1:0]    accum_q;
	logic                  neg_q;
	logic [1:0]            phase_q;
	logic [FRAC_W-1:0]     frac_q;
	logic [ANGLE_W-1:0]    angle_q [3];
	logic [2:0]            upd_q;

	// ---------------------------------------------------------------- result register
	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] yaw_q;
	logic signed [ANGLE_W-1:0] pitch_q;
	logic signed [ANGLE_W-1:0] roll_q;
	logic                      hdr_match_q;
	logic [2:0]                mask_q;

	// ---------------------------------------------------------------- next state
	logic [LINE_CNT_W-1:0] line_cnt_d;
	logic [TOK_W-1:0]      tok_d;
	logic                  inside_d;
	logic [HDR_W-1:0]      hdr_prog_d;
	logic                  hdr_fail_d;
	logic                  dead_d;
	logic [ANGLE_W-1:0]    accum_d;
	logic                  neg_d;
	logic [1:0]            phase_d;
	logic [FRAC_W-1:0]     frac_d;
	logic [ANGLE_W-1:0]    angle_d [3];
	logic [2:0]            upd_d;
	logic [2:0]            mask_d;

	logic                  emit;
	logic                  match_d;
	logic                  end_tok;
	logic                  is_digit;
	logic [ANGLE_W+3:0]    acc_wide;
	logic [ANGLE_W-1:0]    acc_next;
	logic                  advance;
	logic                  fire_s1;

	number_t                   num;
	logic signed [ANGLE_W-1:0] num_value;

	assign num.accum = accum_q;
	assign num.frac  = frac_q;
	assign num.neg   = neg_q;

	ypr_value_scale u_scale (
		.num   (num),
		.value (num_value)
	);

	// Decimal accumulate: accum * 10 + digit, clamped at the magnitude cap.
	assign acc_wide = ((ANGLE_W+4)'(accum_q) << 3) + ((ANGLE_W+4)'(accum_q) << 1)
		+ (ANGLE_W+4)'(byte_s1 - CH_0);
	assign acc_next = (acc_wide > (ANGLE_W+4)'(MAG_CAP)) ? MAG_CAP : acc_wide[ANGLE_W-1:0];
	assign is_digit = (byte_s1 inside {[CH_0:CH_9]});

	// Only a line-ending newline can be held back by a busy result register.
	assign emit    = (byte_s1 == CH_NL) && (line_cnt_q != '0);
	assign advance = !(emit && out_valid_q && !angles.ready);
	assign fire_s1 = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_comb begin
		line_cnt_d = line_cnt_q;
		tok_d      = tok_q;
		inside_d   = inside_q;
		hdr_prog_d = hdr_prog_q;
		hdr_fail_d = hdr_fail_q;
		dead_d     = dead_q;
		accum_d    = accum_q;
		neg_d      = neg_q;
		phase_d    = phase_q;
		frac_d     = frac_q;
		angle_d    = angle_q;
		upd_d      = upd_q;
		end_tok    = 1'b0;
		match_d    = 1'b0;

		// Decide whether this byte closes the current token, then touch the fields.
		if (byte_s1 == CH_NL) begin
			end_tok = emit && !dead_q;
		end else if (line_cnt_q < LINE_CNT_W'(MAX_LINE)) begin
			line_cnt_d = line_cnt_q + 1'b1;
			if (!dead_q) begin
				if (byte_s1 == CH_NUL) begin
					end_tok = 1'b1;
					dead_d  = 1'b1;
				end else if (byte_s1 == CH_EQ || byte_s1 == CH_COMMA) begin
					end_tok = 1'b1;
				end else begin
					inside_d = 1'b1;
					if (tok_q == '0) begin
						if (hdr_prog_q < HDR_LEN && byte_s1 == HDR_TEXT[hdr_prog_q[1:0]])
							hdr_prog_d = hdr_prog_q + 1'b1;
						else
							hdr_fail_d = 1'b1;
					end else if (tok_q <= TOK_W'(3)) begin
						// Number scanner: sign, integer digits, dot, fraction digits.
						if (phase_q == PH_STOP) begin
							phase_d = PH_STOP;
						end else if (phase_q == PH_SIGN
								&& (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS)) begin
							neg_d   = (byte_s1 == CH_MINUS);
							phase_d = PH_INT;
						end else if (is_digit && (phase_q == PH_SIGN || phase_q == PH_INT)) begin
							phase_d = PH_INT;
							accum_d = acc_next;
						end else if (byte_s1 == CH_DOT
								&& (phase_q == PH_SIGN || phase_q == PH_INT)) begin
							phase_d = PH_FRAC;
						end else if (is_digit && phase_q == PH_FRAC) begin
							// Drop fraction digits beyond the kept precision.
							if (frac_q < FRAC_W'(FRAC_DIGITS)) begin
								accum_d = acc_next;
								frac_d  = frac_q + 1'b1;
							end
						end else begin
							phase_d = PH_STOP;
						end
					end
				end
			end
		end

		// Close the token: check the header or store the scanned angle.
		if (end_tok && inside_q) begin
			inside_d = 1'b0;
			case (tok_q)
				TOK_W'(0): begin
					if (hdr_prog_q != HDR_LEN || hdr_fail_q)
						dead_d = 1'b1;
				end
				TOK_W'(1): begin
					angle_d[0] = num_value;
					upd_d[0]   = 1'b1;
				end
				TOK_W'(2): begin
					angle_d[1] = num_value;
					upd_d[1]   = 1'b1;
				end
				TOK_W'(3): begin
					angle_d[2] = num_value;
					upd_d[2]   = 1'b1;
				end
				default: begin
				end
			endcase
			if (tok_q < TOK_W'(4))
				tok_d = tok_q + 1'b1;
			accum_d = '0;
			neg_d   = 1'b0;
			phase_d = PH_SIGN;
			frac_d  = '0;
		end

		match_d = (tok_d != '0) && (hdr_prog_q == HDR_LEN) && !hdr_fail_q;
		// Capture the line's update mask before the per-line state is cleared.
		mask_d  = upd_d;

		// A line-ending newline clears all per-line state as the result register is loaded.
		if (emit) begin
			line_cnt_d = '0;
			tok_d      = '0;
			inside_d   = 1'b0;
			hdr_prog_d = '0;
			hdr_fail_d = 1'b0;
			dead_d     = 1'b0;
			accum_d    = '0;
			neg_d      = 1'b0;
			phase_d    = PH_SIGN;
			frac_d     = '0;
			upd_d      = '0;
		end
	end

	// Input register: take a beat whenever the stage is empty or retiring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	// Parse state: advance once per retiring byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q <= '0;
			tok_q      <= '0;
			inside_q   <= 1'b0;
			hdr_prog_q <= '0;
			hdr_fail_q <= 1'b0;
			dead_q     <= 1'b0;
			accum_q    <= '0;
			neg_q      <= 1'b0;
			phase_q    <= PH_SIGN;
			frac_q     <= '0;
			angle_q    <= '{default: '0};
			upd_q      <= '0;
		end else if (fire_s1) begin
			line_cnt_q <= line_cnt_d;
			tok_q      <= tok_d;
			inside_q   <= inside_d;
			hdr_prog_q <= hdr_prog_d;
			hdr_fail_q <= hdr_fail_d;
			dead_q     <= dead_d;
			accum_q    <= accum_d;
			neg_q      <= neg_d;
			phase_q    <= phase_d;
			frac_q     <= frac_d;
			angle_q    <= angle_d;
			upd_q      <= upd_d;
		end
	end

	// Result register: load on a retiring line end, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (angles.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			yaw_q       <= signed'(angle_d[0]);
			pitch_q     <= signed'(angle_d[1]);
			roll_q      <= signed'(angle_d[2]);
			hdr_match_q <= match_d;
			mask_q      <= mask_d;
		end
	end

	assign angles.valid          = out_valid_q;
	assign angles.yaw_milli      = yaw_q;
	assign angles.pitch_milli    = pitch_q;
	assign angles.roll_milli     = roll_q;
	assign angles.header_matched = hdr_match_q;
	assign angles.updated_mask   = mask_q;

`ifndef SYNTHESIS
	a_clear_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && emit |=> line_cnt_q == '0 && upd_q == '0)
		else $error("line state not cleared after line end");

	a_upd_needs_token: assert property (@(posedge clk) disable iff (!arst_n)
		upd_q != '0 |-> tok_q >= TOK_W'(2))
		else $error("angle marked updated before its token closed");

	a_mask_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mask_q != '0 |-> hdr_match_q)
		else $error("angles updated on a line without the header");

	a_token_not_dead: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> !dead_q)
		else $error("open token on an ignored line");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && emit && out_valid_q && !angles.ready)
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
